// ===== rtl/core/ranked_multiset_with_floor_core_macros.svh =====
// Assertion macros for the ranked multiset core.
// Used by the controller and the datapath; no other dependencies.
`ifndef RANKED_MULTISET_WITH_FLOOR_CORE_MACROS_SVH
`define RANKED_MULTISET_WITH_FLOOR_CORE_MACROS_SVH

// Clocked assertion, disabled during reset.
`define RMF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication built on the one above.
`define RMF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `RMF_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/rmf_pkg.sv =====
// Shared types and constants of the ranked multiset core.
// No dependencies.
package rmf_pkg;
   localparam int CAPACITY_DEF = 1024;
   localparam int VAL_W        = 32;
   localparam int AMT_W        = 31;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_RAISE  = 2'd1,
      ACT_LOWER  = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic rd;
      logic wr;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic at_bottom;
      logic stop;
      logic to_finish;
   } status_type;
endpackage

// ===== rtl/core/ranked_multiset_with_floor_core.sv =====
// Ranked multiset with floor. Steps to the strobe: setup, then result for a
// rejected insert, a failed query or a shift of an empty store; read, write for a
// found query; read then write per entry moved for an insert, ending in a write of
// the value or a read step writing it at the bottom; read then write per held
// value, then finish, for raise or lower. busy stays high through the strobe
// cycle; next start the cycle after. Synchronous reset empties it at once, no sweep.
module ranked_multiset_with_floor_core #(
   parameter int CAPACITY = rmf_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_action,
   input  logic [rmf_pkg::AMT_W-1:0]        req_amount,
   output logic                             strobe,
   output logic                             rsp_found,
   output logic signed [rmf_pkg::VAL_W-1:0] rsp_ranked_value,
   output logic [$clog2(CAPACITY+1)-1:0]    rsp_held_count,
   output logic [rmf_pkg::VAL_W-1:0]        rsp_departed_total,
   output logic                             rsp_full_drop,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rmf_pkg::AMT_W-1:0]        csr_floor_level
);
   import rmf_pkg::*;

   cmd_type    cmd;
   status_type st;

   assign csr_ready = !busy;

   rmf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .st     (st),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (strobe)
   );

   rmf_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_action         (req_action),
      .req_amount         (req_amount),
      .csr_write          (csr_valid && csr_ready),
      .csr_floor_level    (csr_floor_level),
      .rsp_found          (rsp_found),
      .rsp_ranked_value   (rsp_ranked_value),
      .rsp_held_count     (rsp_held_count),
      .rsp_departed_total (rsp_departed_total),
      .rsp_full_drop      (rsp_full_drop)
   );
endmodule

// ===== rtl/core/rmf_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module rmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/rmf_ctrl.sv =====
// Sequencing state machine of the ranked multiset core.
// Depends on rmf_pkg and the assertion macro header.
`include "ranked_multiset_with_floor_core_macros.svh"
module rmf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  rmf_pkg::status_type st,
   output rmf_pkg::cmd_type    cmd,
   output logic               busy,
   output logic               strobe
);
   import rmf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SETUP  = 6'b000010,
      ST_RD     = 6'b000100,
      ST_WR     = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = st.skip ? ST_RESULT : ST_RD;
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = st.at_bottom ? ST_RESULT : ST_WR;
         end
         ST_WR: begin
            cmd.wr = 1'b1;
            if (st.stop) begin
               state_in = st.to_finish ? ST_FINISH : ST_RESULT;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign strobe = (state_ff == ST_RESULT);

   `RMF_ASSERT_NEXT(a_start_setup, clock, reset, start && !busy, state_ff == ST_SETUP, "start not taken")
   `RMF_ASSERT_NEXT(a_result_idle, clock, reset, strobe, !busy, "result not followed by idle")
   `RMF_ASSERT(a_wr_after_rd, clock, reset, state_ff == ST_WR |-> $past(state_ff) == ST_RD, "write step without read")
endmodule

// ===== rtl/core/rmf_dp.sv =====
// Datapath of the ranked multiset core: circular sorted store, counters, results.
// Depends on rmf_pkg, rmf_ram and the assertion macro header.
`include "ranked_multiset_with_floor_core_macros.svh"
module rmf_dp #(
   parameter int CAPACITY = rmf_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rmf_pkg::cmd_type                     cmd,
   output rmf_pkg::status_type                  st,
   input  logic [1:0]                           req_action,
   input  logic [rmf_pkg::AMT_W-1:0]            req_amount,
   input  logic                                 csr_write,
   input  logic [rmf_pkg::AMT_W-1:0]            csr_floor_level,
   output logic                                 rsp_found,
   output logic signed [rmf_pkg::VAL_W-1:0]     rsp_ranked_value,
   output logic [$clog2(CAPACITY+1)-1:0]        rsp_held_count,
   output logic [rmf_pkg::VAL_W-1:0]            rsp_departed_total,
   output logic                                 rsp_full_drop
);
   import rmf_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   action_type         act_ff, act_in;
   logic [AMT_W-1:0]   amt_ff, amt_in;
   logic [AMT_W-1:0]   floor_ff, floor_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      gone_ff, gone_in;
   logic [VAL_W-1:0]   total_ff, total_in;
   logic               found_ff, found_in;
   logic [VAL_W-1:0]   value_ff, value_in;
   logic               drop_ff, drop_in;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [VAL_W-1:0]   ram_wdata, rdata;

   logic signed [VAL_W-1:0] v_ins, floor_s, newv;
   logic signed [VAL_W:0]   sum;
   logic               below, full, q_ok, gt, is_sweep;
   logic [CW-1:0]      q_idx, idx_dn, idx_nx;
   logic [VAL_W:0]     total_sum;

   function automatic logic [AW-1:0] phys(input logic [CW-1:0] i, input logic [AW-1:0] h);
      logic [AW:0] s;
      s = {1'b0, h} + (AW+1)'(i);
      if (s >= (AW+1)'(CAPACITY)) begin
         s = s - (AW+1)'(CAPACITY);
      end
      return s[AW-1:0];
   endfunction

   rmf_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   always_comb begin
      v_ins    = $signed({1'b0, amt_ff});
      floor_s  = $signed({1'b0, floor_ff});
      below    = (amt_ff < floor_ff);
      full     = (count_ff == CW'(CAPACITY));
      q_ok     = (amt_ff != '0) && ({1'b0, amt_ff} <= VAL_W'(count_ff));
      q_idx    = CW'(VAL_W'(count_ff) - {1'b0, amt_ff});
      idx_dn   = idx_ff - CW'(1);
      idx_nx   = idx_ff + CW'(1);
      gt       = $signed(rdata) > v_ins;
      is_sweep = (act_ff == ACT_RAISE) || (act_ff == ACT_LOWER);
      if (act_ff == ACT_RAISE) begin
         sum = $signed({rdata[VAL_W-1], rdata}) + $signed({2'b00, amt_ff});
      end else begin
         sum = $signed({rdata[VAL_W-1], rdata}) - $signed({2'b00, amt_ff});
      end
      if (sum[VAL_W] != sum[VAL_W-1]) begin
         newv = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         newv = sum[VAL_W-1:0];
      end
      total_sum = {1'b0, total_ff} + (VAL_W+1)'(gone_ff);
   end

   always_comb begin
      case (act_ff)
         ACT_INSERT: st.skip = below || full;
         ACT_RAISE,
         ACT_LOWER:  st.skip = (count_ff == '0);
         ACT_QUERY:  st.skip = !q_ok;
         default:    st.skip = 1'b1;
      endcase
      st.at_bottom = (act_ff == ACT_INSERT) && (idx_ff == '0);
      case (act_ff)
         ACT_INSERT: st.stop = !gt;
         ACT_QUERY:  st.stop = 1'b1;
         default:    st.stop = (idx_nx == count_ff);
      endcase
      st.to_finish = is_sweep;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = phys(idx_ff, head_ff);
      ram_raddr = phys(idx_ff, head_ff);
      ram_wdata = v_ins;
      if (cmd.rd) begin
         if (act_ff == ACT_INSERT) begin
            if (idx_ff == '0) begin
               ram_we = 1'b1;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = phys(idx_dn, head_ff);
            end
         end else begin
            ram_re = 1'b1;
         end
      end
      if (cmd.wr) begin
         if (act_ff == ACT_INSERT) begin
            ram_we    = 1'b1;
            ram_wdata = gt ? rdata : v_ins;
         end else if (is_sweep) begin
            ram_we    = 1'b1;
            ram_wdata = newv;
         end
      end
   end

   always_comb begin
      act_in   = act_ff;
      amt_in   = amt_ff;
      floor_in = floor_ff;
      count_in = count_ff;
      head_in  = head_ff;
      idx_in   = idx_ff;
      gone_in  = gone_ff;
      total_in = total_ff;
      found_in = found_ff;
      value_in = value_ff;
      drop_in  = drop_ff;
      if (csr_write) begin
         floor_in = csr_floor_level;
      end
      if (cmd.load) begin
         act_in   = action_type'(req_action);
         amt_in   = req_amount;
         found_in = 1'b0;
         value_in = '0;
         drop_in  = 1'b0;
      end
      if (cmd.setup) begin
         gone_in = '0;
         case (act_ff)
            ACT_INSERT: begin
               drop_in = !below && full;
               idx_in  = count_ff;
            end
            ACT_QUERY: idx_in = q_idx;
            default:   idx_in = '0;
         endcase
      end
      if (cmd.rd && (act_ff == ACT_INSERT) && (idx_ff == '0)) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.wr) begin
         if (act_ff == ACT_INSERT) begin
            if (gt) begin
               idx_in = idx_dn;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end else if (act_ff == ACT_QUERY) begin
            found_in = 1'b1;
            value_in = rdata;
         end else begin
            idx_in = idx_nx;
            if (newv < floor_s) begin
               gone_in = gone_ff + CW'(1);
            end
         end
      end
      if (cmd.finish && (act_ff == ACT_LOWER)) begin
         head_in  = phys(gone_ff, head_ff);
         count_in = count_ff - gone_ff;
         total_in = total_sum[VAL_W] ? '1 : total_sum[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= ACT_INSERT;
         floor_ff <= '0;
         count_ff <= '0;
         head_ff  <= '0;
         idx_ff   <= '0;
         gone_ff  <= '0;
         total_ff <= '0;
         found_ff <= 1'b0;
         drop_ff  <= 1'b0;
      end else begin
         act_ff   <= act_in;
         floor_ff <= floor_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         idx_ff   <= idx_in;
         gone_ff  <= gone_in;
         total_ff <= total_in;
         found_ff <= found_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      amt_ff   <= amt_in;
      value_ff <= value_in;
   end

   assign rsp_found          = found_ff;
   assign rsp_ranked_value   = value_ff;
   assign rsp_held_count     = count_ff;
   assign rsp_departed_total = total_ff;
   assign rsp_full_drop      = drop_ff;

   `RMF_ASSERT(a_count_cap, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `RMF_ASSERT(a_drop_nofound, clock, reset, drop_ff |-> !found_ff, "drop and found together")
   `RMF_ASSERT_NEXT(a_total_mono, clock, reset, 1'b1, total_ff >= $past(total_ff), "departed total fell")
endmodule
